/* hw/rtl/tcce_pkg.sv */
// Shared types, codes and constants of the text console cursor engine.
package tcce_pkg;

  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;
  localparam int QUEUE_DEPTH     = 2;

  localparam int CMD_W      = 2;
  localparam int GLYPH_W    = 8;
  localparam int IDX_W      = 11;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = 16;
  localparam int COL_OUT_W  = 7;
  localparam int LINE_OUT_W = 5;
  localparam int LIN_OUT_W  = 11;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [GLYPH_W-1:0] CH_BS       = 8'h08;
  localparam logic [GLYPH_W-1:0] CH_TAB      = 8'h09;
  localparam logic [GLYPH_W-1:0] CH_LF       = 8'h0A;
  localparam logic [GLYPH_W-1:0] CH_CR       = 8'h0D;
  localparam logic [GLYPH_W-1:0] BLANK_GLYPH = 8'h20;

  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  localparam int TAB_STEP = 4;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_RETURN,
    OP_TAB,
    OP_BACK,
    OP_CLEAR,
    OP_READ,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [GLYPH_W-1:0] glyph;
    logic [IDX_W-1:0]   cell_index;
  } cmd_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0]  cursor_column;
    logic [LINE_OUT_W-1:0] cursor_line;
    logic [LIN_OUT_W-1:0]  cursor_linear;
    logic [CELL_W-1:0]     cell_value;
  } res_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL,
    ST_REPORT
  } st_t;

endpackage

/* hw/rtl/tcce_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/tcce_fifo.sv */
// Small register queue used between the pipeline parts and at the result side.
module tcce_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tcce_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW  = $clog2(DEPTH);
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNW-1:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNW'(do_push) - CNW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

/* hw/rtl/tcce_front.sv */
// Front end: accepts commands, decodes control characters, queues operations.
module tcce_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          hold,
  input  logic                          push,
  output logic                          full,
  input  logic [tcce_pkg::CMD_W-1:0]    cmd,
  input  logic [tcce_pkg::GLYPH_W-1:0]  glyph,
  input  logic [tcce_pkg::IDX_W-1:0]    cell_index,
  output logic                          cmd_valid,
  output tcce_pkg::cmd_t                cmd_head,
  input  logic                          cmd_pop
);

  tcce_pkg::cmd_t entry;
  logic           q_full;
  logic           q_empty;

  always_comb begin
    entry.glyph      = glyph;
    entry.cell_index = cell_index;
    unique case (cmd)
      tcce_pkg::CMD_PUT: begin
        unique case (glyph)
          tcce_pkg::CH_LF:  entry.op = tcce_pkg::OP_NEWLINE;
          tcce_pkg::CH_CR:  entry.op = tcce_pkg::OP_RETURN;
          tcce_pkg::CH_TAB: entry.op = tcce_pkg::OP_TAB;
          tcce_pkg::CH_BS:  entry.op = tcce_pkg::OP_BACK;
          default:          entry.op = tcce_pkg::OP_PUT;
        endcase
      end
      tcce_pkg::CMD_CLEAR: entry.op = tcce_pkg::OP_CLEAR;
      tcce_pkg::CMD_READ:  entry.op = tcce_pkg::OP_READ;
      default:             entry.op = tcce_pkg::OP_NONE;
    endcase
  end

  assign full      = q_full || hold;
  assign cmd_valid = !q_empty;

  tcce_fifo #(
    .WIDTH($bits(tcce_pkg::cmd_t)),
    .DEPTH(tcce_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push && !hold),
    .din  (entry),
    .full (q_full),
    .pop  (cmd_pop),
    .dout (cmd_head),
    .empty(q_empty)
  );

endmodule

/* hw/rtl/tcce_back.sv */
// Back end: executes queued operations on the cell memory and the cursor.
module tcce_back #(
  parameter int COLUMNS = tcce_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcce_pkg::ROWS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [tcce_pkg::ATTR_W-1:0]  cfg_data,
  input  logic                         cmd_valid,
  input  tcce_pkg::cmd_t               cmd_head,
  output logic                         cmd_pop,
  input  logic                         res_full,
  output logic                         res_push,
  output tcce_pkg::res_t               res_data,
  output logic                         init_busy
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int IXW   = (AW >= tcce_pkg::IDX_W) ? AW + 1 : tcce_pkg::IDX_W + 1;

  localparam logic [AW-1:0]  COLS_A    = AW'(COLUMNS);
  localparam logic [AW-1:0]  CELL_LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0]  COPY_LAST = AW'(CELLS - COLUMNS);
  localparam logic [CW-1:0]  COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0]  ROW_LAST  = RW'(ROWS - 1);
  localparam logic [CW:0]    COLS_T    = (CW + 1)'(COLUMNS);
  localparam logic [CW:0]    TAB_MASK  = ~((CW + 1)'(tcce_pkg::TAB_STEP - 1));
  localparam logic [IXW-1:0] CELLS_X   = IXW'(CELLS);

  tcce_pkg::st_t                state;
  tcce_pkg::st_t                state_next;
  logic [CW-1:0]                col;
  logic [CW-1:0]                col_next;
  logic [RW-1:0]                row;
  logic [RW-1:0]                row_next;
  logic [AW-1:0]                sweep;
  logic [AW-1:0]                sweep_next;
  logic [tcce_pkg::CELL_W-1:0]  cell_q;
  logic [tcce_pkg::CELL_W-1:0]  cell_next;
  logic [tcce_pkg::ATTR_W-1:0]  attr;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [tcce_pkg::CELL_W-1:0]  ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [tcce_pkg::CELL_W-1:0]  ram_rdata;

  logic [AW-1:0]                lin;
  logic [CW:0]                  tab_col;
  logic                         idx_ok;
  logic [tcce_pkg::CELL_W-1:0]  blank_cell;

  assign lin        = AW'(row) * COLS_A + AW'(col);
  assign tab_col    = ((CW + 1)'(col) + (CW + 1)'(tcce_pkg::TAB_STEP)) & TAB_MASK;
  assign idx_ok     = IXW'(cmd_head.cell_index) < CELLS_X;
  assign blank_cell = {attr, tcce_pkg::BLANK_GLYPH};
  assign init_busy  = (state == tcce_pkg::ST_INIT);

  assign res_data.cursor_column = tcce_pkg::COL_OUT_W'(col);
  assign res_data.cursor_line   = tcce_pkg::LINE_OUT_W'(row);
  assign res_data.cursor_linear = tcce_pkg::LIN_OUT_W'(lin);
  assign res_data.cell_value    = cell_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= tcce_pkg::ATTR_RESET;
    end else if (cfg_we) begin
      attr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcce_pkg::ST_INIT;
      col   <= '0;
      row   <= '0;
      sweep <= '0;
    end else begin
      state <= state_next;
      col   <= col_next;
      row   <= row_next;
      sweep <= sweep_next;
    end
  end

  always_ff @(posedge clk) begin
    cell_q <= cell_next;
  end

  always_comb begin
    state_next = state;
    col_next   = col;
    row_next   = row;
    sweep_next = sweep;
    cell_next  = cell_q;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = lin;
    ram_wdata  = blank_cell;
    ram_raddr  = '0;

    unique case (state)
      tcce_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = sweep;
        ram_wdata = tcce_pkg::RESET_CELL;
        if (sweep == CELL_LAST) begin
          sweep_next = '0;
          state_next = tcce_pkg::ST_IDLE;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end

      tcce_pkg::ST_IDLE: begin
        if (cmd_valid && !res_full) begin
          cmd_pop    = 1'b1;
          cell_next  = '0;
          state_next = tcce_pkg::ST_REPORT;
          unique case (cmd_head.op)
            tcce_pkg::OP_PUT: begin
              ram_we    = 1'b1;
              ram_wdata = {attr, cmd_head.glyph};
              if (col == COL_LAST) begin
                col_next = '0;
                if (row == ROW_LAST) begin
                  sweep_next = '0;
                  state_next = tcce_pkg::ST_COPY;
                end else begin
                  row_next = row + 1'b1;
                end
              end else begin
                col_next = col + 1'b1;
              end
            end
            tcce_pkg::OP_NEWLINE: begin
              col_next = '0;
              if (row == ROW_LAST) begin
                sweep_next = '0;
                state_next = tcce_pkg::ST_COPY;
              end else begin
                row_next = row + 1'b1;
              end
            end
            tcce_pkg::OP_RETURN: begin
              col_next = '0;
            end
            tcce_pkg::OP_TAB: begin
              if (tab_col >= COLS_T) begin
                col_next = '0;
                if (row == ROW_LAST) begin
                  sweep_next = '0;
                  state_next = tcce_pkg::ST_COPY;
                end else begin
                  row_next = row + 1'b1;
                end
              end else begin
                col_next = tab_col[CW-1:0];
              end
            end
            tcce_pkg::OP_BACK: begin
              if (col != '0) begin
                col_next  = col - 1'b1;
                ram_we    = 1'b1;
                ram_waddr = lin - 1'b1;
              end
            end
            tcce_pkg::OP_CLEAR: begin
              col_next   = '0;
              row_next   = '0;
              sweep_next = '0;
              state_next = tcce_pkg::ST_FILL;
            end
            tcce_pkg::OP_READ: begin
              if (idx_ok) begin
                ram_raddr  = AW'(cmd_head.cell_index);
                state_next = tcce_pkg::ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end

      tcce_pkg::ST_READ: begin
        cell_next  = ram_rdata;
        state_next = tcce_pkg::ST_REPORT;
      end

      tcce_pkg::ST_COPY: begin
        ram_raddr = (sweep == COPY_LAST) ? '0 : sweep + COLS_A;
        if (sweep != '0) begin
          ram_we    = 1'b1;
          ram_waddr = sweep - 1'b1;
          ram_wdata = ram_rdata;
        end
        if (sweep == COPY_LAST) begin
          state_next = tcce_pkg::ST_FILL;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end

      tcce_pkg::ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = sweep;
        if (sweep == CELL_LAST) begin
          state_next = tcce_pkg::ST_REPORT;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end

      tcce_pkg::ST_REPORT: begin
        res_push   = 1'b1;
        state_next = tcce_pkg::ST_IDLE;
      end

      default: begin
        state_next = tcce_pkg::ST_IDLE;
      end
    endcase
  end

  tcce_ram #(
    .WIDTH(tcce_pkg::CELL_W),
    .DEPTH(CELLS)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

/* hw/rtl/text_console_cursor_engine.sv */
// Top level of the text console cursor engine: front end, executor and result queue.
//
// Commands enter through a two-entry command queue; the executor behind it works on one
// command at a time against a single-port-write, single-port-read cell memory of
// ROWS*COLUMNS entries. A printable glyph, carriage return, newline, tab, backspace or
// unused command is executed and then reported into the result queue; a read first
// waits in a read state for the registered memory data. A command that moves the cursor
// past the bottom row adds a scroll (one cell copied or blanked per cycle through the
// memory ports); clear blanks every cell before its report. After reset the memory is
// swept to grey blanks, one cell per cycle, and full stays high for that time; attribute
// writes are taken throughout.
module text_console_cursor_engine #(
  parameter int COLUMNS = tcce_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcce_pkg::ROWS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [tcce_pkg::CMD_W-1:0]       cmd,
  input  logic [tcce_pkg::GLYPH_W-1:0]     glyph,
  input  logic [tcce_pkg::IDX_W-1:0]       cell_index,
  input  logic                             pop,
  output logic                             empty,
  output logic [tcce_pkg::COL_OUT_W-1:0]   cursor_column,
  output logic [tcce_pkg::LINE_OUT_W-1:0]  cursor_line,
  output logic [tcce_pkg::LIN_OUT_W-1:0]   cursor_linear,
  output logic [tcce_pkg::CELL_W-1:0]      cell_value,
  input  logic                             cfg_we,
  input  logic [tcce_pkg::ATTR_W-1:0]      cfg_data
);

  logic           cmd_valid;
  tcce_pkg::cmd_t cmd_head;
  logic           cmd_pop;
  logic           res_full;
  logic           res_push;
  tcce_pkg::res_t res_data;
  tcce_pkg::res_t res_head;
  logic           init_busy;

  tcce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .hold      (init_busy),
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .glyph     (glyph),
    .cell_index(cell_index),
    .cmd_valid (cmd_valid),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop)
  );

  tcce_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd_valid(cmd_valid),
    .cmd_head (cmd_head),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_data),
    .init_busy(init_busy)
  );

  tcce_fifo #(
    .WIDTH($bits(tcce_pkg::res_t)),
    .DEPTH(tcce_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_data),
    .full (res_full),
    .pop  (pop),
    .dout (res_head),
    .empty(empty)
  );

  assign cursor_column = res_head.cursor_column;
  assign cursor_line   = res_head.cursor_line;
  assign cursor_linear = res_head.cursor_linear;
  assign cell_value    = res_head.cell_value;

endmodule
